// ===== rtl/tpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpm_pkg: shared types and constants for the PWM period and duty meter
// Controller states, command and status groups, and datapath widths.
// ----------------------------------------------------------------------------
package tpm_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned DIV_W   = 39;  // avg_high * 100 fits in 39 bits
  localparam int unsigned DCNT_W  = $clog2(DIV_W + 1);
  localparam int unsigned APB_AW  = 3;

  localparam logic [DUTY_W-1:0] DUTY_SCALE = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;

  localparam logic REG_LEVEL_MASK   = 1'b0;
  localparam logic REG_SKIP_REPEATS = 1'b1;

  localparam logic [DATA_W-1:0] LEVEL_MASK_RESET = 32'h0004_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLOAD,
    ST_PDIV,
    ST_HLOAD,
    ST_HDIV,
    ST_MUL,
    ST_DLOAD,
    ST_DDIV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_PERIOD,
    DIV_HIGH,
    DIV_DUTY
  } div_sel_t;

  typedef struct packed {
    logic     take;        // update capture with the accepted request
    logic     hold_acc;    // final request: keep its accepted flag
    logic     load_plain;  // non-final request: load result register
    logic     div_load;
    div_sel_t div_sel;
    logic     div_step;
    logic     save_period;
    logic     save_high;
    logic     mul;
    logic     save_duty;
    logic     finish;      // load final result, clear capture
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/tpm_if.sv =====
// ----------------------------------------------------------------------------
// tpm_if: sample and result channels of the PWM period and duty meter
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tpm_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;
  logic [31:0] stamp;
  logic        final_item;

  modport source (output valid, sample, stamp, final_item, input ready);
  modport sink   (input valid, sample, stamp, final_item, output ready);
endinterface

interface tpm_result_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [31:0] period_cycles;
  logic [6:0]  duty_percent;
  logic        run_done;

  modport source (output valid, accepted, period_cycles, duty_percent, run_done,
                  input ready);
  modport sink   (input valid, accepted, period_cycles, duty_percent, run_done,
                  output ready);
endinterface

// ===== rtl/tpm_datapath.sv =====
// ----------------------------------------------------------------------------
// tpm_datapath: capture state, edge accumulators, divider and result register
// Shared restoring divider, one quotient bit per cycle, for all three divides.
// ----------------------------------------------------------------------------
module tpm_datapath
  import tpm_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [DATA_W-1:0]   in_sample,
  input  logic [DATA_W-1:0]   in_stamp,
  input  logic                cfg_we,
  input  logic                cfg_sel,
  input  logic [DATA_W-1:0]   cfg_wdata,
  output logic [DATA_W-1:0]   level_mask,
  output logic                skip_repeats,
  output logic                out_accepted,
  output logic [DATA_W-1:0]   out_period,
  output logic [DUTY_W-1:0]   out_duty,
  output logic                out_run_done
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [CW-1:0]     stored_count;
  logic [DATA_W-1:0] previous_sample;
  logic              rise_seen;
  logic [DATA_W-1:0] last_rise_stamp;
  logic [DATA_W-1:0] period_sum;
  logic [CW-1:0]     period_count;
  logic [DATA_W-1:0] high_sum;
  logic [CW-1:0]     high_count;

  logic              acc_hold;
  logic [DATA_W-1:0] period_val;
  logic [DATA_W-1:0] avg_high;
  logic [DUTY_W-1:0] duty_val;
  logic [DIV_W-1:0]  prod;

  logic [DIV_W-1:0]  div_q;
  logic [DATA_W-1:0] div_rem;
  logic [DATA_W-1:0] div_dvs;
  logic [DCNT_W-1:0] div_cnt;

  logic              full;
  logic              repeat_hit;
  logic              acc;
  logic              do_store;
  logic              was_high;
  logic              is_high;
  logic [DATA_W:0]   rem_shift;
  logic              q_bit;
  logic [DIV_W-1:0]  div_dividend;
  logic [DATA_W-1:0] div_divisor;

  assign full       = stored_count >= CAP;
  assign repeat_hit = skip_repeats && (stored_count != '0) && (in_sample == previous_sample);
  assign acc        = !full;
  assign do_store   = !full && !repeat_hit;
  assign was_high   = (previous_sample & level_mask) != '0;
  assign is_high    = (in_sample & level_mask) != '0;

  assign rem_shift  = {div_rem, div_q[DIV_W-1]};
  assign q_bit      = rem_shift >= {1'b0, div_dvs};
  assign sts.div_done = div_cnt == DCNT_W'(DIV_W);

  always_comb begin
    case (cmd.div_sel)
      DIV_PERIOD: begin
        div_dividend = DIV_W'(period_sum);
        div_divisor  = DATA_W'(period_count);
      end
      DIV_HIGH: begin
        div_dividend = DIV_W'(high_sum);
        div_divisor  = DATA_W'(high_count);
      end
      DIV_DUTY: begin
        div_dividend = prod;
        div_divisor  = period_val;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_mask   <= LEVEL_MASK_RESET;
      skip_repeats <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_sel == REG_LEVEL_MASK) begin
        level_mask <= cfg_wdata;
      end else begin
        skip_repeats <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      stored_count    <= '0;
      previous_sample <= '0;
      rise_seen       <= 1'b0;
      last_rise_stamp <= '0;
      period_sum      <= '0;
      period_count    <= '0;
      high_sum        <= '0;
      high_count      <= '0;
    end else if (cmd.take && do_store) begin
      if (stored_count != '0) begin
        if (!was_high && is_high) begin
          if (rise_seen) begin
            period_sum   <= period_sum + (last_rise_stamp - in_stamp);
            period_count <= period_count + 1'b1;
          end
          last_rise_stamp <= in_stamp;
          rise_seen       <= 1'b1;
        end else if (was_high && !is_high && rise_seen) begin
          high_sum   <= high_sum + (last_rise_stamp - in_stamp);
          high_count <= high_count + 1'b1;
        end
      end
      previous_sample <= in_sample;
      stored_count    <= stored_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_q   <= div_dividend;
      div_rem <= '0;
      div_dvs <= div_divisor;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_q   <= {div_q[DIV_W-2:0], q_bit};
      div_rem <= q_bit ? DATA_W'(rem_shift - {1'b0, div_dvs}) : rem_shift[DATA_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_acc) begin
      acc_hold <= acc;
    end
    if (cmd.save_period) begin
      period_val <= (period_count == '0) ? '0 : div_q[DATA_W-1:0];
    end
    if (cmd.save_high) begin
      avg_high <= (high_count == '0) ? '0 : div_q[DATA_W-1:0];
    end
    if (cmd.mul) begin
      prod <= DIV_W'(avg_high) * DIV_W'(DUTY_SCALE);
    end
    if (cmd.save_duty) begin
      if (period_val == '0 || high_count == '0) begin
        duty_val <= '0;
      end else if (div_q > DIV_W'(DUTY_MAX)) begin
        duty_val <= DUTY_MAX;
      end else begin
        duty_val <= div_q[DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_plain) begin
      out_accepted <= acc;
      out_period   <= '0;
      out_duty     <= '0;
      out_run_done <= 1'b0;
    end else if (cmd.finish) begin
      out_accepted <= acc_hold;
      out_period   <= period_val;
      out_duty     <= duty_val;
      out_run_done <= 1'b1;
    end
  end

endmodule

// ===== rtl/tpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpm_ctrl: sequencer for the PWM period and duty meter
// Handles the request handshake and steps the final-request divide sequence.
// ----------------------------------------------------------------------------
module tpm_ctrl
  import tpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_final,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   take;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign take     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (take && in_final) state_next = ST_PLOAD;
      ST_PLOAD: state_next = ST_PDIV;
      ST_PDIV:  if (sts.div_done) state_next = ST_HLOAD;
      ST_HLOAD: state_next = ST_HDIV;
      ST_HDIV:  if (sts.div_done) state_next = ST_MUL;
      ST_MUL:   state_next = ST_DLOAD;
      ST_DLOAD: state_next = ST_DDIV;
      ST_DDIV:  if (sts.div_done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_PERIOD;
    case (state)
      ST_IDLE: begin
        cmd.take       = take;
        cmd.hold_acc   = take && in_final;
        cmd.load_plain = take && !in_final;
      end
      ST_PLOAD: cmd.div_load = 1'b1;
      ST_PDIV: begin
        cmd.div_step    = !sts.div_done;
        cmd.save_period = sts.div_done;
      end
      ST_HLOAD: begin
        cmd.div_sel  = DIV_HIGH;
        cmd.div_load = 1'b1;
      end
      ST_HDIV: begin
        cmd.div_sel   = DIV_HIGH;
        cmd.div_step  = !sts.div_done;
        cmd.save_high = sts.div_done;
      end
      ST_MUL: cmd.mul = 1'b1;
      ST_DLOAD: begin
        cmd.div_sel  = DIV_DUTY;
        cmd.div_load = 1'b1;
      end
      ST_DDIV: begin
        cmd.div_sel   = DIV_DUTY;
        cmd.div_step  = !sts.div_done;
        cmd.save_duty = sts.div_done;
      end
      ST_DONE: cmd.finish = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_plain || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/timestamped_pwm_period_duty_meter.sv =====
// ----------------------------------------------------------------------------
// timestamped_pwm_period_duty_meter: PWM period and duty meter
// Measures rise-to-rise period and high time from timestamped port samples.
// ----------------------------------------------------------------------------
// Requests arrive on the samples channel (sample, stamp, final_item); each
// request yields one result on the results channel (accepted, period_cycles,
// duty_percent, run_done). Both channels are valid/ready.
// A non-final request is taken and its result is registered on the next
// edge; such requests sustain one per cycle while the receiver is ready,
// since a new request is taken in the same cycle the waiting result is taken.
// A final request runs three divides through one restoring divider: period,
// high time, then duty after a multiply; each is a load, 39 quotient steps
// and a save. Its result then has period_cycles and duty_percent valid and
// run_done set, once the result register is free. The capture is then
// cleared; level_mask and skip_repeats are kept.
// When the receiver stalls, the result register holds and no new request is
// taken until it drains. Reset (rst, synchronous) clears the capture, sets
// level_mask to 0x40000 and skip_repeats to 0.
// APB registers: 0x0 level_mask, 0x4 skip_repeats; write only while idle.
// ----------------------------------------------------------------------------
module timestamped_pwm_period_duty_meter
  import tpm_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  tpm_sample_if.sink         samples,
  tpm_result_if.source       results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cmd_t              cmd;
  sts_t              sts;
  logic              cfg_we;
  logic              cfg_sel;
  logic [DATA_W-1:0] level_mask;
  logic              skip_repeats;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_we  = psel && penable && pwrite;
  assign prdata  = (cfg_sel == REG_SKIP_REPEATS) ? DATA_W'(skip_repeats) : level_mask;

  tpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_final  (samples.final_item),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tpm_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_sample    (samples.sample),
    .in_stamp     (samples.stamp),
    .cfg_we       (cfg_we),
    .cfg_sel      (cfg_sel),
    .cfg_wdata    (pwdata),
    .level_mask   (level_mask),
    .skip_repeats (skip_repeats),
    .out_accepted (results.accepted),
    .out_period   (results.period_cycles),
    .out_duty     (results.duty_percent),
    .out_run_done (results.run_done)
  );

  a_final_blocks: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready && samples.final_item |=> !samples.ready)
    else $error("final request did not start divide sequence");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.run_done |-> results.duty_percent <= DUTY_MAX)
    else $error("duty above saturation limit");

  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.run_done |->
      results.period_cycles == '0 && results.duty_percent == '0)
    else $error("non-final result carries measurement");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !samples.ready)
    else $error("request taken during divide");

endmodule

// ===== dv/timestamped_pwm_period_duty_meter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_pwm_period_duty_meter_tb: regression for the PWM period/duty meter
// Sends timestamped sample requests over valid/ready with random gaps and
// receiver stalls, predicts every result with a cycle-free model of the
// capture and accumulators, and programs the mask and repeat-skip registers
// over APB between phases, including mid-run mask changes.
// ----------------------------------------------------------------------------
module timestamped_pwm_period_duty_meter_tb;
  import tpm_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned RAND_ITEMS  = 1250;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned END_WAIT    = 150;
  localparam logic [DATA_W-1:0] HI    = LEVEL_MASK_RESET;

  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] period_cycles;
    logic [DUTY_W-1:0] duty_percent;
    logic              run_done;
  } meter_result_t;

  class duty_meter_scoreboard;
    logic [DATA_W-1:0] level_mask;
    logic              skip_repeats;
    int unsigned       stored_count;
    logic [DATA_W-1:0] prev_sample;
    logic              rise_seen;
    logic [DATA_W-1:0] last_rise_stamp;
    logic [DATA_W-1:0] period_sum;
    int unsigned       period_count;
    logic [DATA_W-1:0] high_sum;
    int unsigned       high_count;
    meter_result_t     expected_reports[$];
    int unsigned       mismatches;
    int unsigned       results_checked;
    int unsigned       runs_reported;
    int unsigned       refused;

    function new();
      level_mask   = LEVEL_MASK_RESET;
      skip_repeats = 1'b0;
      mismatches = 0;
      results_checked = 0;
      runs_reported = 0;
      refused = 0;
      clear_capture();
    endfunction

    function void clear_capture();
      stored_count    = 0;
      prev_sample     = '0;
      rise_seen       = 1'b0;
      last_rise_stamp = '0;
      period_sum      = '0;
      period_count    = 0;
      high_sum        = '0;
      high_count      = 0;
    endfunction

    function void write_reg(logic idx, logic [DATA_W-1:0] data);
      if (idx == REG_LEVEL_MASK) begin
        level_mask = data;
      end else begin
        skip_repeats = data[0];
      end
    endfunction

    function void flag(string what, logic [63:0] exp, logic [63:0] got);
      if (exp !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, exp, got);
      end
    endfunction

    function void track_edges(logic [DATA_W-1:0] smp, logic [DATA_W-1:0] stp);
      logic was_high;
      logic is_high;
      was_high = (prev_sample & level_mask) != 0;
      is_high  = (smp & level_mask) != 0;
      if (!was_high && is_high) begin
        if (rise_seen) begin
          period_sum += last_rise_stamp - stp;
          period_count++;
        end
        last_rise_stamp = stp;
        rise_seen = 1'b1;
      end else if (was_high && !is_high && rise_seen) begin
        high_sum += last_rise_stamp - stp;
        high_count++;
      end
    endfunction

    function void note_request(logic [DATA_W-1:0] smp, logic [DATA_W-1:0] stp, logic fin);
      meter_result_t exp;
      logic [63:0]   avg_high;
      logic [63:0]   duty;
      exp = '0;
      if (stored_count >= CAPACITY) begin
        exp.accepted = 1'b0;
        refused++;
      end else if (skip_repeats && stored_count > 0 && smp == prev_sample) begin
        exp.accepted = 1'b1;
      end else begin
        if (stored_count > 0) track_edges(smp, stp);
        prev_sample = smp;
        stored_count++;
        exp.accepted = 1'b1;
      end
      if (fin) begin
        if (period_count != 0) exp.period_cycles = period_sum / period_count;
        if (exp.period_cycles != 0 && high_count != 0) begin
          avg_high = 64'(high_sum / high_count);
          duty = (avg_high * 64'(DUTY_SCALE)) / 64'(exp.period_cycles);
          exp.duty_percent = (duty > 64'(DUTY_MAX)) ? DUTY_MAX : duty[DUTY_W-1:0];
        end
        clear_capture();
        runs_reported++;
      end
      exp.run_done = fin;
      expected_reports.push_back(exp);
    endfunction

    function void check_result(meter_result_t got);
      meter_result_t exp;
      results_checked++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t unexpected result %0h", $realtime, got);
        return;
      end
      exp = expected_reports.pop_front();
      flag("accepted", exp.accepted, got.accepted);
      flag("period_cycles", exp.period_cycles, got.period_cycles);
      flag("duty_percent", exp.duty_percent, got.duty_percent);
      flag("run_done", exp.run_done, got.run_done);
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tpm_sample_if samples_if ();
  tpm_result_if results_if ();

  timestamped_pwm_period_duty_meter #(.CAPACITY(CAPACITY)) DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  duty_meter_scoreboard sb = new();

  bit                no_idle;
  int unsigned       requests_sent;
  int unsigned       settings_applied;
  int unsigned       idle_cycles;
  logic [DATA_W-1:0] timer_now;
  logic [DATA_W-1:0] last_sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: cycles with no request, result or register access.
  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) ||
        (results_if.valid && results_if.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog expired", $realtime);
        $display("timestamped_pwm_period_duty_meter regression: fail");
        $finish;
      end
    end
  end

  // Result receiver with random stalls.
  initial begin
    meter_result_t got;
    int unsigned   stall;
    results_if.ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      repeat (stall) begin
        @(negedge clk);
        results_if.ready <= 1'b0;
      end
      @(negedge clk);
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!(results_if.valid && !rst));
      got.accepted      = results_if.accepted;
      got.period_cycles = results_if.period_cycles;
      got.duty_percent  = results_if.duty_percent;
      got.run_done      = results_if.run_done;
      sb.check_result(got);
    end
  end

  task automatic send(logic [DATA_W-1:0] smp, logic [DATA_W-1:0] stp, logic fin);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk);
      samples_if.valid <= 1'b0;
    end
    @(negedge clk);
    samples_if.valid      <= 1'b1;
    samples_if.sample     <= smp;
    samples_if.stamp      <= stp;
    samples_if.final_item <= fin;
    do @(posedge clk); while (!samples_if.ready);
    sb.note_request(smp, stp, fin);
    last_sent = smp;
    requests_sent++;
  endtask

  task automatic apb_write(logic idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(logic idx, logic [DATA_W-1:0] exp);
    logic [DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.flag(idx == REG_LEVEL_MASK ? "level_mask read" : "skip_repeats read", exp, got);
  endtask

  task automatic drain();
    @(negedge clk);
    samples_if.valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(logic [DATA_W-1:0] mask, logic skip);
    apb_write(REG_LEVEL_MASK, mask);
    apb_write(REG_SKIP_REPEATS, {31'b0, skip});
    reg_check(REG_LEVEL_MASK, mask);
    reg_check(REG_SKIP_REPEATS, {31'b0, skip});
    settings_applied++;
  endtask

  function automatic logic [DATA_W-1:0] level_sample(logic hi);
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] bits;
    r = $urandom;
    m = sb.level_mask;
    if (!hi || m == 0) return r & ~m;
    bits = r & m;
    if (bits == 0) bits = m & (~m + 1);
    return (r & ~m) | bits;
  endfunction

  // One PWM capture: level runs with random hold lengths, plus noise and repeats.
  task automatic pwm_run(int unsigned len, logic close);
    logic [DATA_W-1:0] smp;
    logic              level;
    int unsigned       hold;
    int unsigned       roll;
    level = $urandom_range(0, 1);
    hold  = $urandom_range(1, 4);
    for (int unsigned k = 0; k < len; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        smp = $urandom;
      end else if (roll < 25 && k > 0) begin
        smp = last_sent;
      end else begin
        if (hold == 0) begin
          level = !level;
          hold  = $urandom_range(1, 4);
        end
        hold--;
        smp = level_sample(level);
      end
      timer_now -= ($urandom_range(0, 29) == 0) ? $urandom : $urandom_range(1, 300);
      send(smp, timer_now, close && k == len - 1);
    end
  endtask

  initial begin
    int unsigned       phase;
    int unsigned       phase_start;
    int unsigned       rand_start;
    int unsigned       len;
    int unsigned       roll;
    logic              close;
    logic [DATA_W-1:0] mask;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    samples_if.valid = 1'b0;
    samples_if.sample = '0;
    samples_if.stamp = '0;
    samples_if.final_item = 1'b0;
    no_idle = 1'b0;
    requests_sent = 0;
    settings_applied = 0;
    timer_now = $urandom;
    last_sent = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    reg_check(REG_LEVEL_MASK, LEVEL_MASK_RESET);
    reg_check(REG_SKIP_REPEATS, '0);

    // final on an empty capture
    send('0, '0, 1'b1);
    // high start, fall before any rise, unmasked bits, then a regular wave
    send('1, '1, 1'b0);
    send('0, 32'd2000, 1'b0);
    send(~HI, 32'd1500, 1'b0);
    send(HI, 32'd1000, 1'b0);
    send('0, 32'd900, 1'b0);
    send(HI, 32'd800, 1'b0);
    send('0, 32'd750, 1'b0);
    send(HI, 32'd600, 1'b0);
    send('0, 32'd500, 1'b1);
    // average high time above the period: duty saturates
    send('0, 32'd2000, 1'b0);
    send(HI, 32'd1000, 1'b0);
    send('0, 32'd999, 1'b0);
    send(HI, 32'd990, 1'b0);
    send('0, 32'd0, 1'b1);
    // period accumulator wraps to zero
    send('0, 32'd10, 1'b0);
    send(HI, 32'h0000_0000, 1'b0);
    send('0, 32'hC000_0000, 1'b0);
    send(HI, 32'h8000_0000, 1'b0);
    send('0, 32'h4000_0000, 1'b0);
    send(HI, 32'h0000_0000, 1'b1);

    rand_start = requests_sent;
    phase = 0;
    while (requests_sent - rand_start < RAND_ITEMS) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: set_config('1, 1'b1);
          2: set_config('0, 1'b0);
          3: set_config(32'h0000_0001, 1'b1);
          4: set_config(32'h8000_0000, 1'b0);
          default: begin
            mask = ($urandom_range(0, 1) == 0) ? (32'h1 << $urandom_range(0, 31)) : $urandom;
            set_config(mask, 1'($urandom_range(0, 1)));
          end
        endcase
      end
      no_idle = ($urandom_range(0, 3) == 0);
      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) len = $urandom_range(1, 2);
        else if (roll < 22) len = $urandom_range(58, 75);
        else len = $urandom_range(3, 40);
        // the last capture of a phase may stay open across the register change
        close = (requests_sent - phase_start + len < PHASE_ITEMS) || ($urandom_range(0, 1) == 0);
        pwm_run(len, close);
      end
      phase++;
    end

    drain();
    no_idle = 1'b0;
    repeat (END_WAIT) @(posedge clk);

    $display("covered %0d requests in %0d reported runs, %0d refused on a full capture",
             requests_sent, sb.runs_reported, sb.refused);
    $display("%0d register settings applied, %0d results checked, %0d mismatches",
             settings_applied, sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("timestamped_pwm_period_duty_meter regression: pass");
    end else begin
      $display("timestamped_pwm_period_duty_meter regression: fail");
    end
    $finish;
  end

endmodule
